### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/qft_pkg.sv
// ---------------------------------------------------------------------------
// qft_pkg
// Types, character codes and helpers for the quoted field tokenizer.
// ---------------------------------------------------------------------------
package qft_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SKIP,
		PH_SEEK,
		PH_WORD,
		PH_QUOTE
	} phase_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	localparam logic [1:0] END_NUL   = 2'd0;
	localparam logic [1:0] END_LF    = 2'd1;
	localparam logic [1:0] END_LIMIT = 2'd2;

	localparam logic CFG_FIELD_LIMIT = 1'b0;
	localparam logic CFG_SKIP_LINE   = 1'b1;

	localparam logic [7:0] FIELD_LIMIT_RST = 8'd64;
	localparam logic [7:0] MAX_FIELD_LIMIT = 8'd255;
	localparam logic [7:0] FIELD_COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic [7:0] field_limit;
		logic       skip_first_line;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_scan;
	} in_item_t;

	typedef struct packed {
		logic        field_done;
		logic [7:0]  field_index;
		logic [15:0] field_start;
		logic [15:0] field_length;
		logic        scan_end;
		logic [1:0]  end_kind;
		logic [15:0] end_offset;
		logic [7:0]  field_count;
	} result_t;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT);
	endfunction

	// Clamp an offset of up to 32 bits to the 16-bit result fields.
	function automatic logic [15:0] out16(input logic [31:0] v);
		return (|v[31:16]) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

### hw/rtl/qft_in_stage.sv
// ---------------------------------------------------------------------------
// qft_in_stage
// Input register of the tokenizer: captures one byte transfer per cycle while in_ready is high.
// ---------------------------------------------------------------------------
module qft_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  qft_pkg::in_item_t in_item,
	input  logic              advance,
	output logic              valid_s1,
	output qft_pkg::in_item_t item_s1
);
	import qft_pkg::*;

	// Take a new byte when empty or when the held one moves on this cycle.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

### hw/rtl/qft_parser.sv
// ---------------------------------------------------------------------------
// qft_parser
// Scan state and per-byte field logic; yields at most one result per byte.
// ---------------------------------------------------------------------------
module qft_parser #(
	parameter int OFFSET_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qft_pkg::cfg_t     cfg,
	input  logic              valid_s1,
	input  qft_pkg::in_item_t item_s1,
	input  logic              advance,
	output logic              res_valid,
	output qft_pkg::result_t  res
);
	import qft_pkg::*;

	phase_t                 phase_q, ph_e, ph_n;
	logic [7:0]             ff_q, ff_e, ff_n;
	logic [OFFSET_BITS-1:0] cs_q, cs_e, cs_n;
	logic [OFFSET_BITS-1:0] cl_q, cl_e, cl_n;
	logic [OFFSET_BITS-1:0] pos_q, pos, pos_n;
	logic [OFFSET_BITS-1:0] eoff;
	logic [7:0]             c;
	logic [7:0]             lim;
	logic                   done, ended, closer;
	logic [1:0]             kind;

	function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
		return (&v) ? v : v + OFFSET_BITS'(1);
	endfunction

	assign c = item_s1.data_byte;

	always_comb begin
		lim = (cfg.field_limit == 8'd0) ? 8'd1 : cfg.field_limit;
		if (lim > MAX_FIELD_LIMIT) begin
			lim = MAX_FIELD_LIMIT;
		end
	end

	always_comb begin
		ph_e = phase_q;
		ff_e = ff_q;
		cs_e = cs_q;
		cl_e = cl_q;
		pos  = pos_q;
		// A start byte drops any scan in progress and counts as offset 0.
		if (item_s1.start_scan) begin
			ph_e = cfg.skip_first_line ? PH_SKIP : PH_SEEK;
			ff_e = '0;
			cs_e = '0;
			cl_e = '0;
			pos  = '0;
		end

		ph_n   = ph_e;
		ff_n   = ff_e;
		cs_n   = cs_e;
		cl_n   = cl_e;
		done   = 1'b0;
		ended  = 1'b0;
		kind   = END_NUL;
		eoff   = pos;
		closer = (ph_e == PH_WORD) ? is_sep(c) : (c == CH_QUOTE);

		unique case (ph_e)
			PH_IDLE: begin
			end
			PH_SKIP: begin
				if (c == CH_NUL) begin
					ended = 1'b1;
				end else if (c == CH_LF) begin
					ph_n = PH_SEEK;
				end
			end
			PH_SEEK: begin
				if (c == CH_NUL) begin
					ended = 1'b1;
				end else if (c == CH_LF) begin
					ended = 1'b1;
					kind  = END_LF;
				end else if (!is_sep(c)) begin
					if (ff_e != FIELD_COUNT_MAX) begin
						ff_n = ff_e + 8'd1;
					end
					if (c == CH_QUOTE) begin
						cs_n = sat_inc(pos);
						cl_n = '0;
						ph_n = PH_QUOTE;
					end else begin
						cs_n = pos;
						cl_n = OFFSET_BITS'(1);
						ph_n = PH_WORD;
					end
				end
			end
			PH_WORD, PH_QUOTE: begin
				if (c == CH_NUL || c == CH_LF) begin
					// Line end closes the open field and the scan together.
					done  = 1'b1;
					ended = 1'b1;
					kind  = (c == CH_NUL) ? END_NUL : END_LF;
				end else if (closer) begin
					done = 1'b1;
					if (ff_e >= lim) begin
						ended = 1'b1;
						kind  = END_LIMIT;
						eoff  = sat_inc(pos);
					end else begin
						ph_n = PH_SEEK;
					end
				end else begin
					cl_n = sat_inc(cl_e);
				end
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase

		pos_n = (ph_e != PH_IDLE) ? sat_inc(pos) : pos;
		if (ended) begin
			ph_n = PH_IDLE;
		end
	end

	always_comb begin
		res_valid        = valid_s1 && (done || ended);
		res.field_done   = done;
		res.field_index  = done ? 8'(ff_n - 8'd1) : 8'd0;
		res.field_start  = done ? out16(32'(cs_n)) : 16'd0;
		res.field_length = done ? out16(32'(cl_n)) : 16'd0;
		res.scan_end     = ended;
		res.end_kind     = ended ? kind : END_NUL;
		res.end_offset   = ended ? out16(32'(eoff)) : 16'd0;
		res.field_count  = ended ? ff_n : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ff_q    <= '0;
			cs_q    <= '0;
			cl_q    <= '0;
			pos_q   <= '0;
		end else if (valid_s1 && advance) begin
			phase_q <= ph_n;
			ff_q    <= ff_n;
			cs_q    <= cs_n;
			cl_q    <= cl_n;
			pos_q   <= pos_n;
		end
	end

endmodule

### hw/rtl/qft_out_stage.sv
// ---------------------------------------------------------------------------
// qft_out_stage
// Result register: holds one result until the receiver takes it.
// ---------------------------------------------------------------------------
module qft_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  qft_pkg::result_t res,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_ready,
	output qft_pkg::result_t res_q
);
	import qft_pkg::*;

	// The stage may move when the register is empty or drains this cycle.
	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

### hw/rtl/quoted_field_tokenizer.sv
// ---------------------------------------------------------------------------
// quoted_field_tokenizer
// Splits a byte stream into blank-separated, optionally quoted fields.
// ---------------------------------------------------------------------------
// Usage:
//   Bytes arrive on the s_axis channel, one per transfer; s_axis_tuser marks
//   the first byte of a scan. Bytes outside a scan are dropped silently.
//   Each completed field and each scan end produces one m_axis transfer;
//   m_axis_tlast flags the transfer that ends the scan, and a byte that both
//   closes a field and ends the scan gives a single transfer carrying both.
//   Each byte is held in the input register and its result in the result
//   register, from which the result is presented on m_axis.
//   Throughput is one byte per cycle unless the receiver stalls: the scan
//   state updates in one pass between the input and result registers.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_axis_tready drops only while both are full.
//   Reset empties both registers, ends any scan and loads field_limit = 64,
//   skip_first_line = 0. Write cfg_* only while no byte is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quoted_field_tokenizer #(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// byte input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] start_scan
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [7:0] field_index, [23:8] field_start,
	                                    // [39:24] field_length, [55:40] end_offset,
	                                    // [63:56] field_count
	output logic [2:0]  m_axis_tuser,   // [0] field_done, [2:1] end_kind
	output logic        m_axis_tlast    // scan_end
);
	import qft_pkg::*;

	cfg_t     cfg_q;
	in_item_t in_item, item_s1;
	result_t  res, res_q;
	logic     valid_s1, res_valid, advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.field_limit     <= FIELD_LIMIT_RST;
			cfg_q.skip_first_line <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIELD_LIMIT: cfg_q.field_limit     <= cfg_data;
				CFG_SKIP_LINE:   cfg_q.skip_first_line <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign in_item.data_byte  = s_axis_tdata;
	assign in_item.start_scan = s_axis_tuser;

	qft_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	qft_parser #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	qft_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_q     (res_q)
	);

	assign m_axis_tdata = {res_q.field_count, res_q.end_offset, res_q.field_length,
	                       res_q.field_start, res_q.field_index};
	assign m_axis_tuser = {res_q.end_kind, res_q.field_done};
	assign m_axis_tlast = res_q.scan_end;

	`ASSERT_CLK(a_result_not_empty, clk, arst_n,
		m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tlast),
		"result carries neither a field nor a scan end")

	`ASSERT_CLK(a_limit_end_has_field, clk, arst_n,
		(m_axis_tvalid && m_axis_tlast && m_axis_tuser[2:1] == END_LIMIT) |-> m_axis_tuser[0],
		"field limit end without a completed field")

	`ASSERT_CLK(a_backpressure_source, clk, arst_n,
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready),
		"input stalled while result register can drain")

endmodule
